@@ hw/rtl/plgm_pkg.sv @@
// ----------------------------------------------------------------------------
// plgm_pkg
// Shared widths, codes, item type and the restoring division step for the
// palette gradient colour map.
// ----------------------------------------------------------------------------
`default_nettype none

package plgm_pkg;

   localparam int PALETTE_DEPTH = 16;
   localparam int FRACTION_BITS = 16;

   localparam int POINT_W    = 32;
   localparam int SPAN_W     = 31;
   localparam int LEN_CFG_W  = 5;
   localparam int IDX_W      = 4;
   localparam int COLOUR_W   = 24;
   localparam int CH_W       = 8;
   localparam int CH_COUNT   = COLOUR_W / CH_W;
   localparam int ADDR_W     = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
   localparam int QUO_W      = ADDR_W + FRACTION_BITS;
   localparam int NUM_W      = SPAN_W + ADDR_W;
   localparam int PROD_W     = CH_W + 1 + FRACTION_BITS + 1;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_RANGE_MIN   = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_RANGE_SPAN  = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_PALETTE_LEN = CSR_IDX_W'(2);

   localparam logic OP_MAP   = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   localparam logic [SPAN_W-1:0]    SPAN_RESET = SPAN_W'(256);
   localparam logic [LEN_CFG_W-1:0] LEN_RESET  = LEN_CFG_W'(2);

   typedef struct packed {
      logic                operation;
      logic [IDX_W-1:0]    entry_index;
      logic [COLOUR_W-1:0] entry_colour;
   } item_type;

   // {quotient bit, new remainder}
   typedef logic [SPAN_W:0] step_type;

   function automatic step_type div_step(input logic [SPAN_W-1:0] rem,
                                         input logic              din,
                                         input logic [SPAN_W-1:0] divisor);
      logic [SPAN_W:0] trial;
      logic [SPAN_W:0] diff;
      trial = {rem, din};
      diff  = trial - {1'b0, divisor};
      if (trial >= {1'b0, divisor}) begin
         return {1'b1, diff[SPAN_W-1:0]};
      end else begin
         return {1'b0, trial[SPAN_W-1:0]};
      end
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/plgm_wrap.sv @@
// ----------------------------------------------------------------------------
// plgm_wrap
// Floor-mod of (point - range_min) by the span: one dividend bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module plgm_wrap (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        advance,
   input  logic                                        in_valid,
   input  plgm_pkg::item_type                          in_item,
   input  logic signed [plgm_pkg::POINT_W-1:0]         in_point,
   input  logic signed [plgm_pkg::POINT_W-1:0]         range_min,
   input  logic        [plgm_pkg::SPAN_W-1:0]          span,
   output logic                                        out_valid,
   output plgm_pkg::item_type                          out_item,
   output logic        [plgm_pkg::SPAN_W-1:0]          out_offset
);

   localparam int PW   = plgm_pkg::POINT_W;
   localparam int SW   = plgm_pkg::SPAN_W;
   localparam int DW   = PW + 1;

   logic [DW-1:0] diff;
   logic [DW-1:0] mag;

   logic                 head_v_ff;
   plgm_pkg::item_type   head_item_ff;
   logic                 head_neg_ff;
   logic [PW-1:0]        head_mag_ff;

   logic [PW-1:0]        dv_ff;
   logic [PW-1:0]        dv_neg_ff;
   plgm_pkg::item_type   dv_item_ff [PW];
   logic [SW-1:0]        dv_rem_ff  [PW];
   logic [SW-1:0]        dv_rem_in  [PW];
   logic [PW-1:0]        dv_dvd_ff  [PW];
   logic [PW-1:0]        dv_dvd_in  [PW];

   logic                 fix_v_ff;
   plgm_pkg::item_type   fix_item_ff;
   logic [SW-1:0]        fix_off_ff;
   logic [SW-1:0]        fix_off_in;

   always_comb begin
      diff = {in_point[PW-1], in_point} - {range_min[PW-1], range_min};
      mag  = diff[DW-1] ? (~diff + DW'(1)) : diff;
   end

   always_comb begin
      plgm_pkg::step_type step;
      step         = plgm_pkg::div_step('0, head_mag_ff[PW-1], span);
      dv_rem_in[0] = step[SW-1:0];
      dv_dvd_in[0] = head_mag_ff << 1;
      for (int k = 1; k < PW; k++) begin
         step         = plgm_pkg::div_step(dv_rem_ff[k-1], dv_dvd_ff[k-1][PW-1], span);
         dv_rem_in[k] = step[SW-1:0];
         dv_dvd_in[k] = dv_dvd_ff[k-1] << 1;
      end
   end

   always_comb begin
      if (dv_neg_ff[PW-1] && (dv_rem_ff[PW-1] != '0)) begin
         fix_off_in = span - dv_rem_ff[PW-1];
      end else begin
         fix_off_in = dv_rem_ff[PW-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_v_ff <= 1'b0;
         dv_ff     <= '0;
         fix_v_ff  <= 1'b0;
      end else if (advance) begin
         head_v_ff <= in_valid;
         dv_ff     <= {dv_ff[PW-2:0], head_v_ff};
         fix_v_ff  <= dv_ff[PW-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         head_item_ff  <= in_item;
         head_neg_ff   <= diff[DW-1];
         head_mag_ff   <= mag[PW-1:0];
         dv_neg_ff     <= {dv_neg_ff[PW-2:0], head_neg_ff};
         dv_item_ff[0] <= head_item_ff;
         for (int k = 1; k < PW; k++) begin
            dv_item_ff[k] <= dv_item_ff[k-1];
         end
         dv_rem_ff     <= dv_rem_in;
         dv_dvd_ff     <= dv_dvd_in;
         fix_item_ff   <= dv_item_ff[PW-1];
         fix_off_ff    <= fix_off_in;
      end
   end

   assign out_valid  = fix_v_ff;
   assign out_item   = fix_item_ff;
   assign out_offset = fix_off_ff;

endmodule

`default_nettype wire

@@ hw/rtl/plgm_scale.sv @@
// ----------------------------------------------------------------------------
// plgm_scale
// Position = offset*(len-1)*2^F / span, one quotient bit per stage, then
// split into segment index and fraction.
// ----------------------------------------------------------------------------
`default_nettype none

module plgm_scale (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    advance,
   input  logic                                    in_valid,
   input  plgm_pkg::item_type                      in_item,
   input  logic [plgm_pkg::SPAN_W-1:0]             in_offset,
   input  logic [plgm_pkg::SPAN_W-1:0]             span,
   input  logic [plgm_pkg::ADDR_W-1:0]             len_m1,
   input  logic [plgm_pkg::ADDR_W-1:0]             len_m2,
   output logic                                    out_valid,
   output plgm_pkg::item_type                      out_item,
   output logic [plgm_pkg::ADDR_W-1:0]             out_seg,
   output logic [plgm_pkg::FRACTION_BITS-1:0]      out_frac
);

   localparam int SW = plgm_pkg::SPAN_W;
   localparam int AW = plgm_pkg::ADDR_W;
   localparam int QW = plgm_pkg::QUO_W;
   localparam int NW = plgm_pkg::NUM_W;
   localparam int FB = plgm_pkg::FRACTION_BITS;

   logic                 mul_v_ff;
   plgm_pkg::item_type   mul_item_ff;
   logic [NW-1:0]        mul_num_ff;

   logic [QW-1:0]        dv_ff;
   plgm_pkg::item_type   dv_item_ff [QW];
   logic [SW-1:0]        dv_rem_ff  [QW];
   logic [SW-1:0]        dv_rem_in  [QW];
   logic [QW-1:0]        dv_dvd_ff  [QW];
   logic [QW-1:0]        dv_dvd_in  [QW];
   logic [QW-1:0]        dv_quo_ff  [QW];
   logic [QW-1:0]        dv_quo_in  [QW];

   logic [AW-1:0]        seg_raw;
   logic                 cl_v_ff;
   plgm_pkg::item_type   cl_item_ff;
   logic [AW-1:0]        cl_seg_ff;
   logic [FB-1:0]        cl_frac_ff;

   always_comb begin
      plgm_pkg::step_type step;
      step         = plgm_pkg::div_step(mul_num_ff[NW-1:AW], mul_num_ff[AW-1], span);
      dv_rem_in[0] = step[SW-1:0];
      dv_dvd_in[0] = {mul_num_ff[AW-1:0], {FB{1'b0}}} << 1;
      dv_quo_in[0] = QW'(step[SW]);
      for (int k = 1; k < QW; k++) begin
         step         = plgm_pkg::div_step(dv_rem_ff[k-1], dv_dvd_ff[k-1][QW-1], span);
         dv_rem_in[k] = step[SW-1:0];
         dv_dvd_in[k] = dv_dvd_ff[k-1] << 1;
         dv_quo_in[k] = {dv_quo_ff[k-1][QW-2:0], step[SW]};
      end
   end

   assign seg_raw = dv_quo_ff[QW-1][QW-1:FB];

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_v_ff <= 1'b0;
         dv_ff    <= '0;
         cl_v_ff  <= 1'b0;
      end else if (advance) begin
         mul_v_ff <= in_valid;
         dv_ff    <= {dv_ff[QW-2:0], mul_v_ff};
         cl_v_ff  <= dv_ff[QW-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mul_item_ff   <= in_item;
         mul_num_ff    <= NW'(in_offset) * NW'(len_m1);
         dv_item_ff[0] <= mul_item_ff;
         for (int k = 1; k < QW; k++) begin
            dv_item_ff[k] <= dv_item_ff[k-1];
         end
         dv_rem_ff     <= dv_rem_in;
         dv_dvd_ff     <= dv_dvd_in;
         dv_quo_ff     <= dv_quo_in;
         cl_item_ff    <= dv_item_ff[QW-1];
         cl_seg_ff     <= (seg_raw > len_m2) ? len_m2 : seg_raw;
         cl_frac_ff    <= dv_quo_ff[QW-1][FB-1:0];
      end
   end

   assign out_valid = cl_v_ff;
   assign out_item  = cl_item_ff;
   assign out_seg   = cl_seg_ff;
   assign out_frac  = cl_frac_ff;

endmodule

`default_nettype wire

@@ hw/rtl/plgm_blend.sv @@
// ----------------------------------------------------------------------------
// plgm_blend
// Palette memory (one write, two reads) and per-channel linear blend.
// Writes and reads sit at the same stage, so item order is kept.
// ----------------------------------------------------------------------------
`default_nettype none

module plgm_blend (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    advance,
   input  logic                                    in_valid,
   input  plgm_pkg::item_type                      in_item,
   input  logic [plgm_pkg::ADDR_W-1:0]             in_seg,
   input  logic [plgm_pkg::FRACTION_BITS-1:0]      in_frac,
   output logic                                    out_valid,
   output logic [plgm_pkg::COLOUR_W-1:0]           out_colour
);

   localparam int CW  = plgm_pkg::COLOUR_W;
   localparam int HW  = plgm_pkg::CH_W;
   localparam int NCH = plgm_pkg::CH_COUNT;
   localparam int AW  = plgm_pkg::ADDR_W;
   localparam int FB  = plgm_pkg::FRACTION_BITS;
   localparam int PW  = plgm_pkg::PROD_W;

   logic [CW-1:0] pal_mem [plgm_pkg::PALETTE_DEPTH];

   logic                 wr_en;
   logic                 rd_v_ff;
   logic [CW-1:0]        rd_l_ff;
   logic [CW-1:0]        rd_r_ff;
   logic [FB-1:0]        rd_frac_ff;

   logic                 mul_v_ff;
   logic [CW-1:0]        mul_left_ff;
   logic signed [PW-1:0] mul_prod_ff [NCH];
   logic signed [PW-1:0] mul_prod_in [NCH];

   assign wr_en = advance && in_valid && (in_item.operation == plgm_pkg::OP_WRITE) &&
                  (32'(in_item.entry_index) < 32'(plgm_pkg::PALETTE_DEPTH));

   always_ff @(posedge clock) begin
      if (wr_en) begin
         pal_mem[AW'(in_item.entry_index)] <= in_item.entry_colour;
      end
      if (advance) begin
         rd_l_ff    <= pal_mem[in_seg];
         rd_r_ff    <= pal_mem[in_seg + AW'(1)];
         rd_frac_ff <= in_frac;
      end
   end

   always_comb begin
      logic signed [HW:0] delta;
      for (int c = 0; c < NCH; c++) begin
         delta = $signed({1'b0, rd_r_ff[c*HW +: HW]}) - $signed({1'b0, rd_l_ff[c*HW +: HW]});
         mul_prod_in[c] = delta * $signed({1'b0, rd_frac_ff});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_v_ff  <= 1'b0;
         mul_v_ff <= 1'b0;
      end else if (advance) begin
         rd_v_ff  <= in_valid && (in_item.operation == plgm_pkg::OP_MAP);
         mul_v_ff <= rd_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mul_left_ff <= rd_l_ff;
         mul_prod_ff <= mul_prod_in;
      end
   end

   // left + floor(delta*f / 2^F), exact and within one channel
   always_comb begin
      logic signed [PW-1:0] step_sh;
      for (int c = 0; c < NCH; c++) begin
         step_sh = mul_prod_ff[c] >>> FB;
         out_colour[c*HW +: HW] = mul_left_ff[c*HW +: HW] + step_sh[HW-1:0];
      end
   end

   assign out_valid = mul_v_ff;

endmodule

`default_nettype wire

@@ hw/rtl/palette_gradient_colour_map_core.sv @@
// ----------------------------------------------------------------------------
// palette_gradient_colour_map_core
// Maps a scalar point to a 0xRRGGBB colour on a piecewise-linear gradient
// through a loaded palette.
//
// req_ channel: one item per cycle while req_ready. operation OP_WRITE stores
// entry_colour in palette slot entry_index, no result; OP_MAP maps req_point.
// rsp_ channel: one rsp_colour per map item, in request order.
// csr_ channel: index 0 range_min, 1 range_span, 2 palette_len; always ready.
// Write it only while no item is in flight.
// From acceptance to rsp_valid an item passes through the 32-stage
// remainder pipeline and the 20-stage quotient pipeline. Throughput is one
// item per cycle while the output buffer does not hold the pipeline.
// A two-entry output buffer holds results; req_ready drops only when its
// second entry is full, and the whole pipeline then holds.
// Reset clears the pipeline and the registers (span 256, length 2); palette
// contents are undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module palette_gradient_colour_map_core (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic                                    req_operation,
   input  logic signed [plgm_pkg::POINT_W-1:0]     req_point,
   input  logic [plgm_pkg::IDX_W-1:0]              req_entry_index,
   input  logic [plgm_pkg::COLOUR_W-1:0]           req_entry_colour,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic [plgm_pkg::COLOUR_W-1:0]           rsp_colour,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [plgm_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [plgm_pkg::CSR_DATA_W-1:0]         csr_data
);

   localparam int SW = plgm_pkg::SPAN_W;
   localparam int AW = plgm_pkg::ADDR_W;
   localparam int LW = plgm_pkg::LEN_CFG_W;
   localparam int CW = plgm_pkg::COLOUR_W;

   logic signed [plgm_pkg::POINT_W-1:0] range_min_ff;
   logic [SW-1:0]        span_ff;
   logic [LW-1:0]        len_ff;
   logic [SW-1:0]        span_eff;
   logic [AW-1:0]        len_m1;
   logic [AW-1:0]        len_m2;

   logic                 advance;
   plgm_pkg::item_type   req_item;

   logic                 wr_valid;
   plgm_pkg::item_type   wr_item;
   logic [SW-1:0]        wr_offset;
   logic                 sc_valid;
   plgm_pkg::item_type   sc_item;
   logic [AW-1:0]        sc_seg;
   logic [plgm_pkg::FRACTION_BITS-1:0] sc_frac;
   logic                 bl_valid;
   logic [CW-1:0]        bl_colour;

   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic [CW-1:0]        rsp_colour_ff;
   logic [CW-1:0]        rsp_colour_in;
   logic                 skid_valid_ff;
   logic                 skid_valid_in;
   logic [CW-1:0]        skid_colour_ff;
   logic [CW-1:0]        skid_colour_in;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         range_min_ff <= '0;
         span_ff      <= plgm_pkg::SPAN_RESET;
         len_ff       <= plgm_pkg::LEN_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            plgm_pkg::CSR_RANGE_MIN:   range_min_ff <= csr_data;
            plgm_pkg::CSR_RANGE_SPAN:  span_ff      <= csr_data[SW-1:0];
            plgm_pkg::CSR_PALETTE_LEN: len_ff       <= csr_data[LW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      span_eff = (span_ff == '0) ? SW'(1) : span_ff;
      if (len_ff < LW'(2)) begin
         len_m1 = AW'(1);
      end else if (32'(len_ff) > 32'(plgm_pkg::PALETTE_DEPTH)) begin
         len_m1 = AW'(plgm_pkg::PALETTE_DEPTH - 1);
      end else begin
         len_m1 = AW'(len_ff - LW'(1));
      end
      len_m2 = len_m1 - AW'(1);
   end

   assign advance   = !skid_valid_ff;
   assign req_ready = advance;

   assign req_item.operation    = req_operation;
   assign req_item.entry_index  = req_entry_index;
   assign req_item.entry_colour = req_entry_colour;

   plgm_wrap u_wrap (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_valid   (req_valid && req_ready),
      .in_item    (req_item),
      .in_point   (req_point),
      .range_min  (range_min_ff),
      .span       (span_eff),
      .out_valid  (wr_valid),
      .out_item   (wr_item),
      .out_offset (wr_offset)
   );

   plgm_scale u_scale (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_valid   (wr_valid),
      .in_item    (wr_item),
      .in_offset  (wr_offset),
      .span       (span_eff),
      .len_m1     (len_m1),
      .len_m2     (len_m2),
      .out_valid  (sc_valid),
      .out_item   (sc_item),
      .out_seg    (sc_seg),
      .out_frac   (sc_frac)
   );

   plgm_blend u_blend (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_valid   (sc_valid),
      .in_item    (sc_item),
      .in_seg     (sc_seg),
      .in_frac    (sc_frac),
      .out_valid  (bl_valid),
      .out_colour (bl_colour)
   );

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_colour_in  = rsp_colour_ff;
      skid_valid_in  = skid_valid_ff;
      skid_colour_in = skid_colour_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in  = skid_valid_ff;
         rsp_colour_in = skid_colour_ff;
         skid_valid_in = 1'b0;
      end
      if (advance && bl_valid) begin
         if (!rsp_valid_in) begin
            rsp_valid_in  = 1'b1;
            rsp_colour_in = bl_colour;
         end else begin
            skid_valid_in  = 1'b1;
            skid_colour_in = bl_colour;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_colour_ff  <= rsp_colour_in;
      skid_colour_ff <= skid_colour_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_colour = rsp_colour_ff;

`ifndef SYNTHESIS
   a_skid_behind_rsp: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid entry held without an output item");

   a_skid_holds: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && !rsp_ready) |=> skid_valid_ff)
      else $error("skid entry lost while output stalled");

   a_skid_fill_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(rsp_valid_ff && !rsp_ready))
      else $error("skid filled while output was free");
`endif

endmodule

`default_nettype wire
